FILE: rtl/tea_pkg.sv
// Shared types, constants and the round mixing function of the TEA block cipher.
// Used by tea_cfg, tea_round and tea_block_cipher_top; depends on nothing else.
package tea_pkg;

  localparam int unsigned DefaultRounds = 32;
  localparam logic [31:0] TeaDelta      = 32'h9E37_79B9;

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    CfgKey0 = 2'd0,
    CfgKey1 = 2'd1,
    CfgKey2 = 2'd2,
    CfgKey3 = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } key_t;

  typedef struct packed {
    logic  action;
    word_t first_word;
    word_t second_word;
  } in_t;

  typedef struct packed {
    word_t first_result;
    word_t second_result;
  } out_t;

  // Payload carried down the round pipeline.
  typedef struct packed {
    logic  action;
    word_t y;
    word_t z;
  } stage_t;

  function automatic word_t tea_mix(word_t x, word_t sum, word_t ka, word_t kb);
    word_t a;
    word_t b;
    word_t c;
    a = (x << 4) + ka;
    b = x + sum;
    c = (x >> 5) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

FILE: rtl/tea_block_cipher_top.sv
// TEA block cipher, fully unrolled: one registered stage per round.
// Each accepted input beat passes through every round stage register in order to its output beat.
// Throughput: one 64-bit block per cycle while the output is not stalled; each stage holds one round's two half-rounds.
// Reset (rst_ni, asynchronous, active low) clears all stage valid bits and the key to zero.
// Depends on tea_pkg, tea_cfg and tea_round.
module tea_block_cipher_top #(
  parameter int unsigned ROUNDS = tea_pkg::DefaultRounds
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Input channel: a beat is taken when valid is high and stall is low.
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tea_pkg::in_t  in_data_i,
  // Output channel: the last round stage doubles as the output register.
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tea_pkg::out_t out_data_o,
  // Key write channel: register index 0..3 selects key word 0..3.
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  import tea_pkg::*;

  key_t   key;
  logic   valid [ROUNDS+1];
  logic   ready [ROUNDS+1];
  stage_t data  [ROUNDS+1];

  // The key must only be rewritten while the pipeline is empty (the block does not
  // enforce this), so every stage reads the live key registers directly.
  tea_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_o       (key)
  );

  // Entry of the pipeline.
  assign valid[0]       = in_valid_i;
  assign data[0].action = in_data_i.action;
  assign data[0].y      = in_data_i.first_word;
  assign data[0].z      = in_data_i.second_word;
  assign in_stall_o     = !ready[0];

  // Each stage loads when it is empty or its successor moves on, so bubbles
  // are squeezed out and a stalled output still lets upstream stages fill.
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    tea_round #(
      .ROUNDS    (ROUNDS),
      .ROUND_IDX (r)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[r]),
      .ready_o (ready[r]),
      .data_i  (data[r]),
      .key_i   (key),
      .valid_o (valid[r+1]),
      .ready_i (ready[r+1]),
      .data_o  (data[r+1])
    );
  end

  // Exit of the pipeline: the final stage's register holds the output beat.
  assign ready[ROUNDS]            = !out_stall_i;
  assign out_valid_o              = valid[ROUNDS];
  assign out_data_o.first_result  = data[ROUNDS].y;
  assign out_data_o.second_result = data[ROUNDS].z;

endmodule

FILE: rtl/tea_cfg.sv
// Key register file of the TEA block cipher: four 32-bit key words.
// Depends on tea_pkg for the key type and the register index codes.
module tea_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output tea_pkg::key_t     key_o
);
  import tea_pkg::*;

  key_t key_q;
  key_t key_d;

  assign cfg_ready_o = 1'b1;
  assign key_o       = key_q;

  always_comb begin
    key_d = key_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgKey0: key_d.k0 = cfg_data_i;
        CfgKey1: key_d.k1 = cfg_data_i;
        CfgKey2: key_d.k2 = cfg_data_i;
        CfgKey3: key_d.k3 = cfg_data_i;
        default: key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

endmodule

FILE: rtl/tea_round.sv
// One registered TEA round (both half-rounds) for either direction.
// Depends on tea_pkg for the stage payload type, delta and the mix function.
module tea_round #(
  parameter int unsigned ROUNDS    = tea_pkg::DefaultRounds,
  parameter int unsigned ROUND_IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  tea_pkg::stage_t data_i,
  input  tea_pkg::key_t   key_i,
  output logic            valid_o,
  input  logic            ready_i,
  output tea_pkg::stage_t data_o
);
  import tea_pkg::*;

  // Round sums are fixed per stage: encryption uses delta*(r+1),
  // decryption walks the rounds backward from delta*ROUNDS.
  localparam logic [63:0] EncProd = 64'(TeaDelta) * 64'(ROUND_IDX + 1);
  localparam logic [63:0] DecProd = 64'(TeaDelta) * 64'(ROUNDS - ROUND_IDX);
  localparam word_t       EncSum  = EncProd[31:0];
  localparam word_t       DecSum  = DecProd[31:0];

  logic   valid_q;
  stage_t data_q;
  stage_t data_d;
  word_t  sum;
  word_t  y_enc;
  word_t  z_enc;
  word_t  z_dec;
  word_t  y_dec;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    sum   = data_i.action ? DecSum : EncSum;
    y_enc = data_i.y + tea_mix(data_i.z, sum, key_i.k0, key_i.k1);
    z_enc = data_i.z + tea_mix(y_enc, sum, key_i.k2, key_i.k3);
    z_dec = data_i.z - tea_mix(data_i.y, sum, key_i.k2, key_i.k3);
    y_dec = data_i.y - tea_mix(z_dec, sum, key_i.k0, key_i.k1);
    data_d.action = data_i.action;
    data_d.y      = data_i.action ? y_dec : y_enc;
    data_d.z      = data_i.action ? z_dec : z_enc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
